// ----- rtl/phtp_pkg.sv -----
// Shared types, constants and helper functions for the PES header timestamp parser.
// No dependencies; every other file imports this package.
`default_nettype none

package phtp_pkg;

  // Header window and counters
  localparam int HEADER_BYTES_DEF = 34;
  localparam int SNAP_BYTES       = 34;
  localparam int IDX_W            = 17;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  // Header byte positions
  localparam int POS_STREAM_ID  = 3;
  localparam int POS_MARKER     = 6;
  localparam int POS_PES_FLAGS  = 7;
  localparam int POS_HDR_LEN    = 8;
  localparam int POS_PTS_MPEG2  = 9;
  localparam int POS_DTS_MPEG2  = 14;
  localparam int STUFF_FIRST    = 6;
  localparam int STUFF_LAST     = 22;
  localparam int FLAG_POS_LAST  = 24;
  localparam int STAMP_BYTES    = 5;

  // Header lengths
  localparam int BASE_W         = 9;
  localparam int POS_W          = 5;
  localparam int SKIP_W         = 10;
  localparam logic [BASE_W-1:0] FIXED_HDR_LEN  = BASE_W'(6);
  localparam logic [BASE_W-1:0] MPEG2_HDR_BASE = BASE_W'(9);
  localparam logic [BASE_W-1:0] MPEG1_LEN_NONE = BASE_W'(1);
  localparam logic [BASE_W-1:0] MPEG1_LEN_PTS  = BASE_W'(5);
  localparam logic [BASE_W-1:0] MPEG1_LEN_BOTH = BASE_W'(10);
  localparam logic [POS_W-1:0]  STD_BUF_LEN    = POS_W'(2);

  // Byte codes
  localparam logic [7:0] SID_PROG_MAP   = 8'hBC;
  localparam logic [7:0] SID_PADDING    = 8'hBE;
  localparam logic [7:0] SID_PRIVATE_2  = 8'hBF;
  localparam logic [7:0] SID_RES_B0     = 8'hB0;
  localparam logic [7:0] SID_RES_B1     = 8'hB1;
  localparam logic [7:0] SID_DIRECTORY  = 8'hFF;
  localparam logic [7:0] SID_DSMCC      = 8'hF2;
  localparam logic [7:0] SID_TYPE_E     = 8'hF8;
  localparam logic [7:0] STUFF_BYTE     = 8'hFF;
  localparam logic [1:0] MPEG2_MARK     = 2'b10;
  localparam logic [1:0] STD_BUF_MARK   = 2'b01;

  // Timestamp scaling: usec = 11*v + v/9, v/9 by reciprocal multiply
  localparam int STAMP_W     = 33;
  localparam int USEC_W      = 37;
  localparam int RECIP_SHIFT = 37;
  localparam int RECIP_W     = 34;
  localparam int RECIP_LO_W  = 17;
  localparam int RECIP_HI_W  = RECIP_W - RECIP_LO_W;
  localparam logic [RECIP_W-1:0] RECIP9 =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd7) / 64'd9);
  localparam int PROD_W      = STAMP_W + RECIP_LO_W;
  localparam int SUM_W       = PROD_W + RECIP_LO_W;
  localparam int QUOT_W      = 30;

  // Configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = CFG_ADDR_W - 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXTRA_SKIP = 1'b0
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_STUFFING = 2'd1,
    ST_SHORT    = 2'd2
  } status_t;

  typedef logic [SNAP_BYTES-1:0][7:0] hdr_bytes_t;

  // Header snapshot taken with the last byte of a packet
  typedef struct packed {
    hdr_bytes_t       hdr;
    logic [IDX_W-1:0] len;
  } snap_t;

  // Decoded header, before the extra skip and length check
  typedef struct packed {
    logic               stuff_err;
    logic               has_pts;
    logic               has_dts;
    logic [7:0]         stream_id;
    logic [BASE_W-1:0]  hdr_len;
    logic [IDX_W-1:0]   len;
    logic [STAMP_W-1:0] pts;
    logic [STAMP_W-1:0] dts;
  } dec_t;

  // Stream ids that carry only the fixed 6-byte header
  function automatic logic is_fixed_hdr_id(input logic [7:0] id);
    logic r;
    case (id)
      SID_PROG_MAP, SID_PADDING, SID_PRIVATE_2, SID_RES_B0,
      SID_RES_B1, SID_DIRECTORY, SID_DSMCC, SID_TYPE_E: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Gather the 33 timestamp bits from five header bytes, dropping markers
  function automatic logic [STAMP_W-1:0] stamp_bits(input logic [7:0] b0,
                                                    input logic [7:0] b1,
                                                    input logic [7:0] b2,
                                                    input logic [7:0] b3,
                                                    input logic [7:0] b4);
    return {b0[3:1], b1, b2[7:1], b3, b4[7:1]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/phtp_window.sv -----
// Header window, byte counter and packet length hold; snapshots the masked header.
// Depends on phtp_pkg.
`default_nettype none

module phtp_window #(
  parameter int HEADER_BYTES = phtp_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic [7:0]                 data_byte,
  input  wire logic                       first_byte,
  input  wire logic [phtp_pkg::IDX_W-1:0] packet_length,
  input  wire logic                       snap_load,
  output phtp_pkg::snap_t                 snap
);
  import phtp_pkg::*;

  logic [HEADER_BYTES-1:0][7:0] win_r, win_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt, idx_cur;
  logic [IDX_W-1:0] len_r, len_nxt;
  snap_t snap_r, snap_nxt;

  // Window update: clear on a new packet, then store the byte at its index
  always_comb begin
    idx_cur = first_byte ? '0 : idx_r;
    len_nxt = first_byte ? packet_length : len_r;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (first_byte) begin
        win_nxt[i] = '0;
      end else begin
        win_nxt[i] = win_r[i];
      end
      if (idx_cur == IDX_W'(i)) begin
        win_nxt[i] = data_byte;
      end
    end
    idx_nxt = (idx_cur == IDX_MAX) ? idx_cur : idx_cur + 1'b1;
  end

  // Bytes at or past the packet length read as zero
  always_comb begin
    for (int i = 0; i < SNAP_BYTES; i++) begin
      snap_nxt.hdr[i] = (IDX_W'(i) < len_nxt) ? win_nxt[i] : '0;
    end
    snap_nxt.len = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      idx_r <= '0;
      len_r <= '0;
    end else if (accept) begin
      win_r <= win_nxt;
      idx_r <= idx_nxt;
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap = snap_r;

endmodule

`default_nettype wire

// ----- rtl/phtp_decode.sv -----
// Header form detection, stuffing search and timestamp field extraction.
// Depends on phtp_pkg.
`default_nettype none

module phtp_decode (
  input  wire logic      clk,
  input  wire logic      load,
  input  wire phtp_pkg::snap_t snap,
  output phtp_pkg::dec_t  dec
);
  import phtp_pkg::*;

  hdr_bytes_t h;
  logic [7:0] sid, mark_byte, flag_byte;
  logic fixed_hdr, mpeg2, all_stuff;
  logic [POS_W-1:0] stuff_end, flag_pos;
  logic [STAMP_W-1:0] pts1, dts1;
  dec_t dec_nxt, dec_r;

  assign h         = snap.hdr;
  assign sid       = h[POS_STREAM_ID];
  assign fixed_hdr = is_fixed_hdr_id(sid);
  assign mpeg2     = (h[POS_MARKER][7:6] == MPEG2_MARK);

  // MPEG-1 stuffing run: first byte that is not 0xFF
  always_comb begin
    all_stuff = 1'b1;
    stuff_end = POS_W'(STUFF_LAST);
    for (int j = STUFF_LAST; j >= STUFF_FIRST; j--) begin
      if (h[j] != STUFF_BYTE) begin
        all_stuff = 1'b0;
        stuff_end = POS_W'(j);
      end
    end
  end

  // Optional STD buffer field ahead of the timestamp flags
  always_comb begin
    mark_byte = '0;
    for (int j = STUFF_FIRST; j <= STUFF_LAST; j++) begin
      if (stuff_end == POS_W'(j)) begin
        mark_byte = h[j];
      end
    end
    flag_pos = (mark_byte[7:6] == STD_BUF_MARK) ? POS_W'(stuff_end + STD_BUF_LEN)
                                                : stuff_end;
  end

  // Flag byte and both timestamp fields at the MPEG-1 position
  always_comb begin
    flag_byte = '0;
    pts1      = '0;
    dts1      = '0;
    for (int j = STUFF_FIRST; j <= FLAG_POS_LAST; j++) begin
      if (flag_pos == POS_W'(j)) begin
        flag_byte = h[j];
        pts1 = stamp_bits(h[j], h[j+1], h[j+2], h[j+3], h[j+4]);
        dts1 = stamp_bits(h[j+STAMP_BYTES], h[j+STAMP_BYTES+1], h[j+STAMP_BYTES+2],
                          h[j+STAMP_BYTES+3], h[j+STAMP_BYTES+4]);
      end
    end
  end

  // Pick the header form
  always_comb begin
    dec_nxt           = '0;
    dec_nxt.stream_id = sid;
    dec_nxt.len       = snap.len;
    if (fixed_hdr) begin
      dec_nxt.hdr_len = FIXED_HDR_LEN;
    end else if (mpeg2) begin
      dec_nxt.hdr_len = BASE_W'(h[POS_HDR_LEN]) + MPEG2_HDR_BASE;
      if (h[POS_PES_FLAGS][7]) begin
        dec_nxt.has_pts = 1'b1;
        dec_nxt.pts = stamp_bits(h[POS_PTS_MPEG2], h[POS_PTS_MPEG2+1],
                                 h[POS_PTS_MPEG2+2], h[POS_PTS_MPEG2+3],
                                 h[POS_PTS_MPEG2+4]);
        if (h[POS_PES_FLAGS][6]) begin
          dec_nxt.has_dts = 1'b1;
          dec_nxt.dts = stamp_bits(h[POS_DTS_MPEG2], h[POS_DTS_MPEG2+1],
                                   h[POS_DTS_MPEG2+2], h[POS_DTS_MPEG2+3],
                                   h[POS_DTS_MPEG2+4]);
        end
      end
    end else if (all_stuff) begin
      dec_nxt.stuff_err = 1'b1;
    end else if (flag_byte[5]) begin
      dec_nxt.has_pts = 1'b1;
      dec_nxt.pts     = pts1;
      if (flag_byte[4]) begin
        dec_nxt.has_dts = 1'b1;
        dec_nxt.dts     = dts1;
        dec_nxt.hdr_len = BASE_W'(flag_pos) + MPEG1_LEN_BOTH;
      end else begin
        dec_nxt.hdr_len = BASE_W'(flag_pos) + MPEG1_LEN_PTS;
      end
    end else begin
      dec_nxt.hdr_len = BASE_W'(flag_pos) + MPEG1_LEN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec = dec_r;

endmodule

`default_nettype wire

// ----- rtl/phtp_scale.sv -----
// Two-stage scaling of a 33-bit timestamp by 100/9: 11*v plus v/9 by reciprocal.
// Depends on phtp_pkg.
`default_nettype none

module phtp_scale (
  input  wire logic                         clk,
  input  wire logic                         en_mul,
  input  wire logic                         en_sum,
  input  wire logic [phtp_pkg::STAMP_W-1:0] stamp,
  output logic      [phtp_pkg::USEC_W-1:0]  usec
);
  import phtp_pkg::*;

  logic [PROD_W-1:0] prod_lo_r, prod_hi_r;
  logic [USEC_W-1:0] x11_r, x11_s_r, x11_nxt;
  logic [SUM_W-1:0]  recip_sum;
  logic [QUOT_W-1:0] quot_r;

  // 11*v from shifts
  assign x11_nxt = (USEC_W'(stamp) << 3) + (USEC_W'(stamp) << 1) + USEC_W'(stamp);

  // Partial products of v and the reciprocal of 9
  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_lo_r <= PROD_W'(stamp) * PROD_W'(RECIP9[RECIP_LO_W-1:0]);
      prod_hi_r <= PROD_W'(stamp) * PROD_W'(RECIP9[RECIP_W-1:RECIP_LO_W]);
      x11_r     <= x11_nxt;
    end
  end

  // Combine the partials; the top bits are v/9
  assign recip_sum = SUM_W'(prod_lo_r) + (SUM_W'(prod_hi_r) << RECIP_LO_W);

  always_ff @(posedge clk) begin
    if (en_sum) begin
      quot_r  <= recip_sum[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
      x11_s_r <= x11_r;
    end
  end

  assign usec = x11_s_r + USEC_W'(quot_r);

endmodule

`default_nettype wire

// ----- rtl/pes_header_timestamp_parser_core.sv -----
// PES header timestamp parser: one byte per cycle in unless stalled, one result word per
// packet.
// Throughput: one byte word every cycle unless stalled; five register stages (snapshot,
// decode, multiply, reciprocal sum, output) advance independently under backpressure.
// Reset: rst_n synchronous, active low; clears the window, counters, extra_skip and
// all stage valids.
`default_nettype none

module pes_header_timestamp_parser_core #(
  parameter int HEADER_BYTES = phtp_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [phtp_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [phtp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [phtp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  // byte input
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_data_byte,
  input  wire logic                            in_first_byte,
  input  wire logic                            in_last_byte,
  input  wire logic [phtp_pkg::IDX_W-1:0]      in_packet_length,
  // results
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [1:0]                      out_status,
  output logic      [7:0]                      out_stream_id,
  output logic      [phtp_pkg::SKIP_W-1:0]     out_payload_offset,
  output logic                                 out_has_pts,
  output logic                                 out_has_dts,
  output logic      [phtp_pkg::USEC_W-1:0]     out_pts_usec,
  output logic      [phtp_pkg::USEC_W-1:0]     out_dts_usec
);
  import phtp_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [7:0]        stream_id;
    logic [SKIP_W-1:0] payload_offset;
    logic              has_pts;
    logic              has_dts;
  } fin_t;

  logic [7:0] extra_r;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic v1_r, v2_r, v3_r, v4_r, out_v_r;
  logic en1, en2, en3, en4, en_out, in_acc;
  snap_t snap;
  dec_t dec;
  fin_t fin_nxt, s3_r, s4_r, out_fin_r;
  logic [SKIP_W-1:0] skip_sum;
  logic [USEC_W-1:0] pts_usec, dts_usec, out_pts_r, out_dts_r;

  // Configuration register
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];

  always_comb begin
    case (cfg_idx)
      REG_EXTRA_SKIP: prdata = CFG_DATA_W'(extra_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extra_r <= '0;
    end else if (psel && penable && pwrite && pready && cfg_idx == REG_EXTRA_SKIP) begin
      extra_r <= pwdata[7:0];
    end
  end

  // Stage enables: a stage loads when empty or when its word moves on
  assign en_out   = !out_v_r || out_ready;
  assign en4      = !v4_r || en_out;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid && in_last_byte;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
      if (en_out) begin
        out_v_r <= v4_r;
      end
    end
  end

  // Window and header snapshot
  phtp_window #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_acc),
    .data_byte    (in_data_byte),
    .first_byte   (in_first_byte),
    .packet_length(in_packet_length),
    .snap_load    (in_acc && in_last_byte),
    .snap         (snap)
  );

  // Header decode
  phtp_decode u_decode (
    .clk (clk),
    .load(en2),
    .snap(snap),
    .dec (dec)
  );

  // Payload offset and status
  always_comb begin
    skip_sum = dec.stuff_err ? '0 : SKIP_W'(dec.hdr_len) + SKIP_W'(extra_r);
    fin_nxt.stream_id      = dec.stream_id;
    fin_nxt.payload_offset = skip_sum;
    if (dec.stuff_err) begin
      fin_nxt.status = ST_STUFFING;
    end else if (dec.len <= IDX_W'(skip_sum)) begin
      fin_nxt.status = ST_SHORT;
    end else begin
      fin_nxt.status = ST_OK;
    end
    fin_nxt.has_pts = dec.has_pts && (fin_nxt.status == ST_OK);
    fin_nxt.has_dts = dec.has_dts && (fin_nxt.status == ST_OK);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_r <= fin_nxt;
    end
    if (en4) begin
      s4_r <= s3_r;
    end
  end

  // Timestamp scaling
  phtp_scale u_scale_pts (
    .clk   (clk),
    .en_mul(en3),
    .en_sum(en4),
    .stamp (dec.pts),
    .usec  (pts_usec)
  );

  phtp_scale u_scale_dts (
    .clk   (clk),
    .en_mul(en3),
    .en_sum(en4),
    .stamp (dec.dts),
    .usec  (dts_usec)
  );

  // Output register; timestamps forced to zero when absent or on error
  always_ff @(posedge clk) begin
    if (en_out) begin
      out_fin_r <= s4_r;
      out_pts_r <= s4_r.has_pts ? pts_usec : '0;
      out_dts_r <= s4_r.has_dts ? dts_usec : '0;
    end
  end

  assign out_valid          = out_v_r;
  assign out_status         = out_fin_r.status;
  assign out_stream_id      = out_fin_r.stream_id;
  assign out_payload_offset = out_fin_r.payload_offset;
  assign out_has_pts        = out_fin_r.has_pts;
  assign out_has_dts        = out_fin_r.has_dts;
  assign out_pts_usec       = out_pts_r;
  assign out_dts_usec       = out_dts_r;

endmodule

`default_nettype wire
